@@ rtl/sr1u_pkg.sv @@
// Shared types, codes and widths of the symmetric rank-one update block.
`default_nettype none

package sr1u_pkg;

  // Fixed field widths.
  localparam int IDX_W  = 4;
  localparam int VAL_W  = 16;
  localparam int WV_W   = 32;
  localparam int PROD_W = 48;
  localparam int TERM_W = 36;
  localparam int ACC_W  = 48;

  // Word index of the only configuration register.
  localparam logic CFG_ONLY_UPPER = 1'b0;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PUSH  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DROP = 2'd2
  } status_e;

  // Kind of result that the datapath loads into the output register.
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_READ,
    RES_PUSH,
    RES_DROP
  } res_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;        // latch the fields of an accepted item
    logic push_start;  // start a push: weight, w*v product, pair counter
    logic drop;        // dropped push: empty the buffer on last
    logic clr_step;    // write zero at the sweep address
    logic read_issue;  // read the matrix entry of a read item
    logic buf_rd;      // read the buffered element at the pair counter
    logic opnd;        // select the partner element of the next pair
    logic mul;         // form the product and read the first entry
    logic rnd;         // round the product to the entry format
    logic wr1;         // write the first entry of the pair
    logic rd2;         // read the mirrored entry
    logic wr2;         // write the mirrored entry, advance the pair counter
    logic fin;         // store the new element, update the count
    logic out_load;    // load the output register
    res_e res;
  } sr1u_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic push_ok;     // the offered push is neither full nor out of range
    logic self_pair;   // all buffered elements are done, self pair is next
    logic clr_last;    // sweep address is at the last entry
  } sr1u_sts_t;

endpackage

`default_nettype wire

@@ rtl/symmetric_rank_one_update.sv @@
// Usage: each input transfer carries one operation: clear the matrix, push one
// observation element (index, value, weight, last) or read one entry (index,
// column). Every accepted item yields exactly one result transfer with
// read_data and status. The only_upper register sits at APB word 0.
// A push works through the single matrix memory port pair: each
// buffered element costs one read-modify-write of (new, old) and one of
// (old, new), and the self pair adds one more; the shared multiplier and
// rounding stages sit in front of each pair.
// One item is worked on at a time; in_ready is high only while idle. The
// result sits in an output register, so a new item is accepted while the
// previous result waits; a stalled receiver stops the block only when the
// next result is ready to load.
// After reset the block sweeps the matrix to zero with in_ready low;
// configuration writes are taken during the sweep.
`default_nettype none

module symmetric_rank_one_update #(
  parameter int DIM       = 16,
  parameter int MAX_ELEMS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [3:0]         index_i,
  input  logic [3:0]         column_i,
  input  logic signed [15:0] value_i,
  input  logic signed [15:0] weight_i,
  input  logic               last_i,
  // Output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [47:0] read_data_o,
  output logic [1:0]         status_o
);
  import sr1u_pkg::*;

  logic      only_upper_q;
  sr1u_cmd_t cmd;
  sr1u_sts_t sts;

  // Configuration register write and read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      only_upper_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == CFG_ONLY_UPPER)) begin
      only_upper_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_ONLY_UPPER) ? {31'd0, only_upper_q} : 32'd0;

  sr1u_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sr1u_dp #(
    .DIM       (DIM),
    .MAX_ELEMS (MAX_ELEMS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .only_upper_i (only_upper_q),
    .index_i      (index_i),
    .column_i     (column_i),
    .value_i      (value_i),
    .weight_i     (weight_i),
    .last_i       (last_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .read_data_o  (read_data_o),
    .status_o     (status_o)
  );

endmodule

`default_nettype wire

@@ rtl/sr1u_ctrl.sv @@
// Sequencing state machine of the symmetric rank-one update block.
`default_nettype none

module sr1u_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            operation_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  sr1u_pkg::sr1u_sts_t   sts_i,
  output sr1u_pkg::sr1u_cmd_t   cmd_o
);
  import sr1u_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_RDA,
    S_LOAD,
    S_OPND,
    S_MUL,
    S_RND,
    S_WR1,
    S_RD2,
    S_WR2,
    S_FIN,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  res_e   res_q, res_d;

  // Next state and command decode.
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          case (op_e'(operation_i))
            OP_CLEAR: begin
              res_d   = RES_ZERO;
              state_d = S_CLR;
            end
            OP_PUSH: begin
              if (sts_i.push_ok) begin
                cmd_o.push_start = 1'b1;
                res_d            = RES_PUSH;
                state_d          = S_LOAD;
              end else begin
                cmd_o.drop = 1'b1;
                res_d      = RES_DROP;
                state_d    = S_OUT;
              end
            end
            OP_READ: begin
              res_d   = RES_READ;
              state_d = S_RDA;
            end
            default: begin
              res_d   = RES_ZERO;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_OUT;
        end
      end
      S_RDA: begin
        cmd_o.read_issue = 1'b1;
        state_d          = S_OUT;
      end
      S_LOAD: begin
        cmd_o.buf_rd = 1'b1;
        state_d      = S_OPND;
      end
      S_OPND: begin
        cmd_o.opnd = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_RND;
      end
      S_RND: begin
        cmd_o.rnd = 1'b1;
        state_d   = S_WR1;
      end
      S_WR1: begin
        cmd_o.wr1 = 1'b1;
        state_d   = sts_i.self_pair ? S_FIN : S_RD2;
      end
      S_RD2: begin
        cmd_o.rd2 = 1'b1;
        state_d   = S_WR2;
      end
      S_WR2: begin
        cmd_o.wr2 = 1'b1;
        state_d   = S_LOAD;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        // Wait until the output register is free or is being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd_o.res = res_q;
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
      res_q       <= RES_ZERO;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/sr1u_dp.sv @@
// Datapath: element buffer, matrix memory, multiply, round and saturating add.
`default_nettype none

module sr1u_dp #(
  parameter int DIM       = 16,
  parameter int MAX_ELEMS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         only_upper_i,
  input  logic [sr1u_pkg::IDX_W-1:0]   index_i,
  input  logic [sr1u_pkg::IDX_W-1:0]   column_i,
  input  logic signed [sr1u_pkg::VAL_W-1:0] value_i,
  input  logic signed [sr1u_pkg::VAL_W-1:0] weight_i,
  input  logic                         last_i,
  input  sr1u_pkg::sr1u_cmd_t          cmd_i,
  output sr1u_pkg::sr1u_sts_t          sts_o,
  output logic signed [sr1u_pkg::ACC_W-1:0] read_data_o,
  output logic [1:0]                   status_o
);
  import sr1u_pkg::*;

  localparam int ENTRIES = DIM * DIM;
  localparam int AW      = $clog2(ENTRIES);
  localparam int CW      = $clog2(MAX_ELEMS + 1);
  localparam int BW      = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int BUF_W   = IDX_W + VAL_W;

  localparam logic [AW-1:0] DIM_A     = AW'(DIM);
  localparam logic [AW-1:0] LAST_A    = AW'(ENTRIES - 1);
  localparam logic [6:0]    DIM_LIM   = 7'(DIM);
  localparam logic [CW-1:0] MAX_C     = CW'(MAX_ELEMS);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Item fields.
  logic [IDX_W-1:0]        idx_q, col_q;
  logic signed [VAL_W-1:0] val_q;
  logic                    last_q;

  // Push state.
  logic [CW-1:0]            count_q, k_q;
  logic signed [VAL_W-1:0]  wt_q, w_sel;
  logic signed [WV_W-1:0]   wv_q, wv_d;
  logic [IDX_W-1:0]         bi_q;
  logic signed [VAL_W-1:0]  bv_q;
  logic signed [PROD_W-1:0] prod_q, rnd_sum;
  logic signed [TERM_W-1:0] term_q;
  logic                     sat_q;
  logic [AW-1:0]            clr_addr_q;

  // Memories.
  logic [BUF_W-1:0]        buf_mem [MAX_ELEMS];
  logic [BUF_W-1:0]        buf_rd_q;
  logic [ACC_W-1:0]        mat_mem [ENTRIES];
  logic signed [ACC_W-1:0] mat_rd_q;

  // Output register.
  logic signed [ACC_W-1:0] read_data_q;
  status_e                 status_q;

  // Matrix port control.
  logic                    mat_we, mat_re;
  logic [AW-1:0]           mat_waddr, mat_raddr, addr1, addr2, addr_rd;
  logic [ACC_W-1:0]        mat_wdata;
  logic signed [ACC_W:0]   acc_sum;
  logic                    acc_ovf;
  logic signed [ACC_W-1:0] acc_new;
  logic                    skip1, skip2, self_pair, rd_in_range;

  function automatic logic [AW-1:0] mat_addr(input logic [IDX_W-1:0] row,
                                             input logic [IDX_W-1:0] col);
    return AW'(row) * DIM_A + AW'(col);
  endfunction

  // Status toward the controller.
  assign self_pair        = (k_q == count_q);
  assign sts_o.push_ok    = (count_q < MAX_C) && ({3'b000, index_i} < DIM_LIM);
  assign sts_o.self_pair  = self_pair;
  assign sts_o.clr_last   = (clr_addr_q == LAST_A);

  // The weight is taken from the item when the buffer is empty.
  assign w_sel = (count_q == '0) ? weight_i : wt_q;
  assign wv_d  = w_sel * value_i;

  // Round half up to 24 fraction bits: add half an LSB, keep the upper bits.
  assign rnd_sum = prod_q + 48'sd2048;

  // Saturating accumulate of the rounded term into the entry just read.
  assign acc_sum = {mat_rd_q[ACC_W-1], mat_rd_q}
                 + {{(ACC_W + 1 - TERM_W){term_q[TERM_W-1]}}, term_q};
  assign acc_ovf = acc_sum[ACC_W] ^ acc_sum[ACC_W-1];
  assign acc_new = acc_ovf ? (acc_sum[ACC_W] ? ACC_MIN : ACC_MAX) : acc_sum[ACC_W-1:0];

  // Lower-triangle entries are left alone when only the upper half is kept.
  assign skip1 = only_upper_i && (bi_q < idx_q);
  assign skip2 = only_upper_i && (idx_q < bi_q);

  assign addr1       = mat_addr(idx_q, bi_q);
  assign addr2       = mat_addr(bi_q, idx_q);
  assign addr_rd     = mat_addr(idx_q, col_q);
  assign rd_in_range = ({3'b000, idx_q} < DIM_LIM) && ({3'b000, col_q} < DIM_LIM);

  // Matrix port selection.
  always_comb begin
    mat_we    = cmd_i.clr_step || (cmd_i.wr1 && !skip1) || (cmd_i.wr2 && !skip2);
    mat_waddr = cmd_i.clr_step ? clr_addr_q : (cmd_i.wr1 ? addr1 : addr2);
    mat_wdata = cmd_i.clr_step ? '0 : acc_new;
    mat_re    = cmd_i.read_issue || cmd_i.mul || cmd_i.rd2;
    mat_raddr = cmd_i.read_issue ? addr_rd : (cmd_i.mul ? addr1 : addr2);
  end

  // Matrix memory.
  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= mat_wdata;
    end
    if (mat_re) begin
      mat_rd_q <= mat_mem[mat_raddr];
    end
  end

  // Element buffer memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      buf_mem[count_q[BW-1:0]] <= {idx_q, val_q};
    end
    if (cmd_i.buf_rd && !self_pair) begin
      buf_rd_q <= buf_mem[k_q[BW-1:0]];
    end
  end

  // Count, weight, pair counter, saturation flag and sweep address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      wt_q       <= '0;
      k_q        <= '0;
      sat_q      <= 1'b0;
      clr_addr_q <= '0;
    end else begin
      if (cmd_i.push_start) begin
        k_q   <= '0;
        sat_q <= 1'b0;
        if (count_q == '0) begin
          wt_q <= weight_i;
        end
      end
      if (cmd_i.wr2) begin
        k_q <= k_q + 1'b1;
      end
      if ((cmd_i.wr1 && !skip1 && acc_ovf) || (cmd_i.wr2 && !skip2 && acc_ovf)) begin
        sat_q <= 1'b1;
      end
      if (cmd_i.fin) begin
        count_q <= last_q ? '0 : count_q + 1'b1;
      end
      if (cmd_i.drop && last_i) begin
        count_q <= '0;
      end
      if (cmd_i.clr_step) begin
        clr_addr_q <= sts_o.clr_last ? '0 : clr_addr_q + 1'b1;
      end
    end
  end

  // Operand and arithmetic pipeline registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      idx_q  <= index_i;
      col_q  <= column_i;
      val_q  <= value_i;
      last_q <= last_i;
    end
    if (cmd_i.push_start) begin
      wv_q <= wv_d;
    end
    if (cmd_i.opnd) begin
      bi_q <= self_pair ? idx_q : buf_rd_q[BUF_W-1:VAL_W];
      bv_q <= self_pair ? val_q : signed'(buf_rd_q[VAL_W-1:0]);
    end
    if (cmd_i.mul) begin
      prod_q <= wv_q * bv_q;
    end
    if (cmd_i.rnd) begin
      term_q <= rnd_sum[PROD_W-1:PROD_W-TERM_W];
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.res)
        RES_READ: begin
          read_data_q <= rd_in_range ? mat_rd_q : '0;
          status_q    <= ST_OK;
        end
        RES_PUSH: begin
          read_data_q <= '0;
          status_q    <= sat_q ? ST_SAT : ST_OK;
        end
        RES_DROP: begin
          read_data_q <= '0;
          status_q    <= ST_DROP;
        end
        default: begin
          read_data_q <= '0;
          status_q    <= ST_OK;
        end
      endcase
    end
  end

  assign read_data_o = read_data_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

@@ rtl/sr1u_checker.sv @@
// Port-level assertions for the symmetric rank-one update block and its bind.
`default_nettype none

module sr1u_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [47:0] read_data_o,
  input logic [1:0]  status_o
);
  import sr1u_pkg::*;

  // A stalled result keeps its payload until the transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o) && $stable(status_o))
    else $error("result changed while stalled");

  // A result with a status other than OK carries zero data.
  a_flagged_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> read_data_o == '0)
    else $error("flagged result carries data");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while busy");

  // A new result appears exactly when the block returns to idle.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result loaded while busy");

endmodule

bind symmetric_rank_one_update sr1u_checker u_sr1u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .read_data_o (read_data_o),
  .status_o    (status_o)
);

`default_nettype wire
